// ----- rtl/cipf_pkg.sv -----
// ----------------------------------------------------------------------------
// Column ink profile package
// Shared widths, constants, the column record that the front half hands to the
// back half and the finished feature set of one column.
// ----------------------------------------------------------------------------
`default_nettype none

package cipf_pkg;

   // Largest supported column height and derived widths.
   localparam int MaxRows     = 1024;
   localparam int RowW        = 10;
   localparam int CountW      = 11;
   localparam int ColW        = 16;
   localparam int DarkSumW    = 18;
   localparam int RowSumW     = 20;
   localparam int GreyW       = 8;
   localparam int DivW        = 20;
   localparam int DivCntW     = 5;

   localparam logic [CountW-1:0] RowsReset = CountW'(64);
   localparam logic [CountW-1:0] RowsMax   = CountW'(MaxRows);
   localparam logic [GreyW-1:0]  GreyWhite = 8'd255;
   localparam logic [DivCntW-1:0] DivLast  = DivCntW'(DivW - 1);

   // Stream payload widths, padded to whole bytes.
   localparam int ReqDataW = 16;
   localparam int RspDataW = 80;

   // Running sums of one finished column.
   typedef struct packed {
      logic [ColW-1:0]     column_index;
      logic [DarkSumW-1:0] darkness_sum;
      logic [CountW-1:0]   rows;
      logic [CountW-1:0]   ink_total;
      logic [RowW-1:0]     first_row;
      logic [RowW-1:0]     last_row;
      logic [RowW-1:0]     edge_total;
      logic [RowSumW-1:0]  row_sum;
      logic                seen_ink;
   } record_type;

   // Finished feature set of one column.
   typedef struct packed {
      logic                column_empty;
      logic [RowW-1:0]     centre_row;
      logic [RowW-1:0]     transitions;
      logic [RowW-1:0]     bottom_row;
      logic [RowW-1:0]     top_row;
      logic [CountW-1:0]   ink_count;
      logic [GreyW-1:0]    mean_darkness;
      logic [ColW-1:0]     column_index;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/cipf_front.sv -----
// ----------------------------------------------------------------------------
// Column ink profile front end
// Accepts pixels, keeps the per-column running sums and emits one record at the
// last row of each column.
// ----------------------------------------------------------------------------
`default_nettype none

module cipf_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_wr_en,
   input  wire  [cipf_pkg::CountW-1:0]  csr_wr_data,
   input  wire                          pix_valid,
   output logic                         pix_ready,
   input  wire                          pix_ink,
   input  wire  [cipf_pkg::GreyW-1:0]   pix_grey,
   output logic                         rec_valid,
   input  wire                          rec_ready,
   output cipf_pkg::record_type         rec_data
);
   import cipf_pkg::*;

   logic [CountW-1:0]   rows_ff, rows_in;
   logic [RowW-1:0]     row_ff, row_in;
   logic [ColW-1:0]     col_ff, col_in;
   logic                prev_ff, prev_in;
   logic                seen_ff, seen_in;
   logic [RowW-1:0]     first_ff, first_in;
   logic [RowW-1:0]     last_ff, last_in;
   logic [CountW-1:0]   ink_ff, ink_in;
   logic [RowW-1:0]     edge_ff, edge_in;
   logic [DarkSumW-1:0] dark_ff, dark_in;
   logic [RowSumW-1:0]  rsum_ff, rsum_in;

   logic [CountW-1:0]   rows_eff;
   logic                end_row;
   logic                accept;

   // Clamp the row count into the supported range.
   always_comb begin
      rows_eff = rows_ff;
      if (rows_ff == '0) begin
         rows_eff = CountW'(1);
      end else if (rows_ff > RowsMax) begin
         rows_eff = RowsMax;
      end
   end

   assign end_row   = ({1'b0, row_ff} + CountW'(1)) >= rows_eff;
   assign pix_ready = !end_row || rec_ready;
   assign accept    = pix_valid && pix_ready;
   assign rec_valid = pix_valid && end_row;

   // Sums including the current pixel.
   always_comb begin
      seen_in  = seen_ff;
      first_in = first_ff;
      last_in  = last_ff;
      ink_in   = ink_ff;
      edge_in  = edge_ff;
      dark_in  = dark_ff;
      rsum_in  = rsum_ff;
      if (pix_ink) begin
         if (!seen_ff) begin
            first_in = row_ff;
         end
         last_in = row_ff;
         seen_in = 1'b1;
         ink_in  = ink_ff + CountW'(1);
         dark_in = dark_ff + DarkSumW'(GreyWhite - pix_grey);
         rsum_in = rsum_ff + RowSumW'(row_ff);
         if (row_ff != '0 && !prev_ff) begin
            edge_in = edge_ff + RowW'(1);
         end
      end
      prev_in = pix_ink;
      row_in  = row_ff + RowW'(1);
      col_in  = col_ff + ColW'(1);
   end

   // Record of the column that ends on this pixel.
   always_comb begin
      rec_data.column_index = col_ff;
      rec_data.darkness_sum = dark_in;
      rec_data.rows         = rows_eff;
      rec_data.ink_total    = ink_in;
      rec_data.first_row    = first_in;
      rec_data.last_row     = last_in;
      rec_data.edge_total   = edge_in;
      rec_data.row_sum      = rsum_in;
      rec_data.seen_ink     = seen_in;
   end

   // Row count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RowsReset;
      end else if (csr_wr_en) begin
         rows_ff <= csr_wr_data;
      end
   end

   // Per-column state.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         prev_ff  <= 1'b0;
         seen_ff  <= 1'b0;
         first_ff <= '0;
         last_ff  <= '0;
         ink_ff   <= '0;
         edge_ff  <= '0;
         dark_ff  <= '0;
         rsum_ff  <= '0;
      end else if (accept) begin
         if (end_row) begin
            row_ff   <= '0;
            col_ff   <= col_in;
            prev_ff  <= 1'b0;
            seen_ff  <= 1'b0;
            first_ff <= '0;
            last_ff  <= '0;
            ink_ff   <= '0;
            edge_ff  <= '0;
            dark_ff  <= '0;
            rsum_ff  <= '0;
         end else begin
            row_ff   <= row_in;
            prev_ff  <= prev_in;
            seen_ff  <= seen_in;
            first_ff <= first_in;
            last_ff  <= last_in;
            ink_ff   <= ink_in;
            edge_ff  <= edge_in;
            dark_ff  <= dark_in;
            rsum_ff  <= rsum_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cipf_queue.sv -----
// ----------------------------------------------------------------------------
// Column ink profile record queue
// Two-entry queue that decouples the pixel front end from the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cipf_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  cipf_pkg::record_type  in_data,
   output logic                  out_valid,
   input  wire                   out_ready,
   output cipf_pkg::record_type  out_data
);
   import cipf_pkg::*;

   record_type  slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cipf_back.sv -----
// ----------------------------------------------------------------------------
// Column ink profile back end
// Runs the two divisions of a column record on one shared radix-2 divider and
// holds the finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cipf_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   rec_valid,
   output logic                  rec_ready,
   input  cipf_pkg::record_type  rec_data,
   output logic                  res_valid,
   input  wire                   res_ready,
   output cipf_pkg::result_type  res_data
);
   import cipf_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDivA = 2'd1;
   localparam logic [1:0] StDivB = 2'd2;
   localparam logic [1:0] StHold = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [DivW-1:0]    quo_ff, quo_in;
   logic [CountW-1:0]  rem_ff, rem_in;
   logic [CountW-1:0]  dvs_ff, dvs_in;
   logic [RowSumW-1:0] rsum_ff, rsum_in;
   result_type         res_ff, res_in;

   logic [CountW:0]    rem_sh;
   logic               fits;
   logic [CountW:0]    rem_sub;
   logic [CountW-1:0]  rem_step;
   logic [DivW-1:0]    quo_step;

   // One restoring division step.
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DivW-1]};
      fits     = rem_sh >= {1'b0, dvs_ff};
      rem_sub  = rem_sh - {1'b0, dvs_ff};
      rem_step = fits ? rem_sub[CountW-1:0] : rem_sh[CountW-1:0];
      quo_step = {quo_ff[DivW-2:0], fits};
   end

   assign rec_ready = state_ff == StIdle;
   assign res_valid = state_ff == StHold;
   assign res_data  = res_ff;

   // Sequencer: load, darkness mean, centre row, hold.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      rsum_in  = rsum_ff;
      res_in   = res_ff;
      case (state_ff)
         StIdle: begin
            if (rec_valid) begin
               res_in.column_index  = rec_data.column_index;
               res_in.ink_count     = rec_data.ink_total;
               res_in.top_row       = rec_data.first_row;
               res_in.bottom_row    = rec_data.last_row;
               res_in.transitions   = rec_data.edge_total;
               res_in.column_empty  = !rec_data.seen_ink;
               res_in.mean_darkness = '0;
               res_in.centre_row    = '0;
               quo_in   = DivW'(rec_data.darkness_sum);
               rem_in   = '0;
               dvs_in   = rec_data.rows;
               rsum_in  = rec_data.row_sum;
               cnt_in   = '0;
               state_in = StDivA;
            end
         end
         StDivA: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + DivCntW'(1);
            if (cnt_ff == DivLast) begin
               res_in.mean_darkness = quo_step[GreyW-1:0];
               quo_in   = DivW'(rsum_ff);
               rem_in   = '0;
               dvs_in   = res_ff.ink_count;
               cnt_in   = '0;
               state_in = StDivB;
            end
         end
         StDivB: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + DivCntW'(1);
            if (cnt_ff == DivLast) begin
               res_in.centre_row = res_ff.column_empty ? '0 : quo_step[RowW-1:0];
               state_in = StHold;
            end
         end
         StHold: begin
            if (res_ready) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      rsum_ff <= rsum_in;
      res_ff  <= res_in;
   end

endmodule

`default_nettype wire

// ----- rtl/column_ink_profile_features.sv -----
// ----------------------------------------------------------------------------
// Column ink profile features
// Per-column ink statistics of a word image streamed one pixel per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels arrive on the req_ stream, column by column, top row first. Each
//   pixel transfer carries the ink bit and grey level. csr_wr_data sets the
//   rows per column (0 acts as 1, above 1024 acts as 1024); write it while idle.
//   One result per column leaves on the rsp_ stream after its last pixel.
// Throughput:
//   The front end takes one pixel per cycle unless the queue is full at the
//   end of a column. Each column result then passes through a two-entry
//   record queue and a shared radix-2 divider that runs two 20-step
//   divisions; the back end takes a new record only after the receiver has
//   taken the last result. Columns that arrive faster than the back end
//   finishes them fill the queue and stall the input.
// Reset and stalls:
//   Reset sets rows per column to 64 and clears all sums and the column number.
//   A stalled receiver holds the result; pixels are still taken until the
//   queue is full at the end of a column.
// ----------------------------------------------------------------------------
`default_nettype none

module column_ink_profile_features (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_wr_en,
   input  wire  [cipf_pkg::CountW-1:0]     csr_wr_data,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // [0] ink, [8:1] grey_level, [15:9] zero
   input  wire  [cipf_pkg::ReqDataW-1:0]   req_tdata,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // [15:0] column_index, [23:16] mean_darkness, [34:24] ink_count,
   // [44:35] top_row, [54:45] bottom_row, [64:55] transitions,
   // [74:65] centre_row, [75] column_empty, [79:76] zero
   output logic [cipf_pkg::RspDataW-1:0]   rsp_tdata
);
   import cipf_pkg::*;

   record_type front_rec;
   logic       front_valid;
   logic       front_ready;
   record_type back_rec;
   logic       back_valid;
   logic       back_ready;
   result_type result;

   cipf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pix_valid   (req_tvalid),
      .pix_ready   (req_tready),
      .pix_ink     (req_tdata[0]),
      .pix_grey    (req_tdata[8:1]),
      .rec_valid   (front_valid),
      .rec_ready   (front_ready),
      .rec_data    (front_rec)
   );

   cipf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_rec),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_rec)
   );

   cipf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (back_valid),
      .rec_ready (back_ready),
      .rec_data  (back_rec),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res_data  (result)
   );

   // Result fields packed from the lowest bit up.
   assign rsp_tdata = {4'b0000, result};

endmodule

`default_nettype wire
